### sv/clta_pkg.sv
// Package for the processor-load threshold alarm.
// Widths, register indexes, event codes, sequencer states and constants.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package clta_pkg;

  localparam int TICK_W     = 64;
  localparam int DELTA_W    = 32;
  localparam int PCT_W      = 7;
  localparam int LVL_W      = 3;
  localparam int EV_W       = 3;
  localparam int PM_W       = 10;
  localparam int RUN_W      = 5;
  localparam int LIM_W      = 11;
  localparam int PROD_W     = 42;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM  = 2'd3;

  // event codes on the result channel
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_RAISE   = 3'd1;
  localparam logic [EV_W-1:0] EV_CLEAR   = 3'd2;
  localparam logic [EV_W-1:0] EV_BLOCKED = 3'd3;
  localparam logic [EV_W-1:0] EV_IGNORED = 3'd4;

  localparam logic signed [RUN_W-1:0] SAMPLES_TO_ALARM = 5'sd3;
  localparam logic signed [RUN_W-1:0] RUN_IDLE         = -5'sd1;
  localparam logic signed [RUN_W-1:0] RUN_ONE          = 5'sd1;
  localparam logic signed [RUN_W-1:0] RUN_ZERO         = 5'sd0;

  localparam logic [PM_W-1:0]    PERMILLE_MAX = 10'd1000;
  localparam logic [PROD_W-1:0]  PROD_MAX     = 42'd1000;
  localparam logic [PM_W-1:0]    PM_SCALE     = 10'd1000;
  localparam logic [LIM_W-1:0]   PCT_SCALE    = 11'd10;
  localparam logic [PCT_W-1:0]   PCT_FULL     = 7'd100;
  localparam logic [CNT_W-1:0]   DIV_LAST     = CNT_W'(PROD_W - 1);

  localparam logic [PCT_W-1:0] LOWER_RESET  = 7'd0;
  localparam logic [PCT_W-1:0] UPPER_RESET  = 7'd100;
  localparam logic [LVL_W-1:0] REPORT_RESET = 3'd0;
  localparam logic [LVL_W-1:0] ALARM_RESET  = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### sv/clta_in_if.sv
// Input channel of the load alarm: one tick snapshot per word.
// Depends on clta_pkg for the field widths.
`default_nettype none

interface clta_in_if;
  logic                        valid;
  logic                        ready;
  logic [clta_pkg::TICK_W-1:0] total_ticks;
  logic [clta_pkg::TICK_W-1:0] idle_ticks;

  modport source (output valid, output total_ticks, output idle_ticks, input ready);
  modport sink   (input valid, input total_ticks, input idle_ticks, output ready);
endinterface

`default_nettype wire

### sv/clta_out_if.sv
// Result channel of the load alarm: event, busy share and run counter.
// Depends on clta_pkg for the field widths.
`default_nettype none

interface clta_out_if;
  logic                             valid;
  logic                             ready;
  logic [clta_pkg::EV_W-1:0]        event_res;
  logic [clta_pkg::PM_W-1:0]        busy_permille;
  logic signed [clta_pkg::RUN_W-1:0] run_count;

  modport source (output valid, output event_res, output busy_permille, output run_count,
                  input ready);
  modport sink   (input valid, input event_res, input busy_permille, input run_count,
                  output ready);
endinterface

`default_nettype wire

### sv/cpu_load_threshold_alarm.sv
// Processor-load alarm with hysteresis and a persistence count.
// Depends on clta_pkg, clta_in_if and clta_out_if.
//
// Usage:
//   in_if carries cumulative total/idle tick snapshots; out_if returns one word per
//   snapshot: event code, busy share in thousandths and the run counter after it.
//   cfg_we/cfg_index/cfg_data write the lower/upper limits (percent) and the report
//   and alarm levels; write them only while no snapshot is in flight.
//   A sampled snapshot, once accepted, passes the busy*1000 product, then the
//   restoring subtract/compare unit (one quotient bit per cycle), then the limit
//   compare and counter update, which loads the result register. A snapshot that
//   is not sampled (limits disabled or invalid) goes straight to that final step.
//   A new snapshot is taken only once the last one has left the final step;
//   in_if.ready is high only while the sequencer is idle.
//   The result sits in an output register; a new snapshot may be accepted while
//   it waits. If the receiver stalls, the next result waits in the final step
//   until the register frees, so nothing is lost.
//   Reset (rst_n low, synchronous): snapshot cleared to zero, run counter -1,
//   registers to 0, 100, 0, 1, output empty.
`default_nettype none

module cpu_load_threshold_alarm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  clta_in_if.sink                                in_if,
  clta_out_if.source                             out_if,
  input  wire logic                              cfg_we,
  input  wire logic [clta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [clta_pkg::CFG_DATA_W-1:0]   cfg_data
);

  clta_pkg::state_t state_r, state_nxt;

  logic [clta_pkg::PCT_W-1:0] lower_r, upper_r;
  logic [clta_pkg::LVL_W-1:0] report_r, alarm_r;

  // only the low 32 bits of a snapshot ever reach the deltas
  logic [clta_pkg::DELTA_W-1:0] prev_total_r, prev_idle_r;
  logic [clta_pkg::DELTA_W-1:0] snap_total_r, snap_idle_r;
  logic signed [clta_pkg::RUN_W-1:0] over_run_r;

  logic [clta_pkg::DELTA_W-1:0] dt_r, busy_r, rem_r;
  logic [clta_pkg::PROD_W-1:0]  dq_r;
  logic [clta_pkg::CNT_W-1:0]   cnt_r;

  logic                               out_valid_r;
  logic [clta_pkg::EV_W-1:0]          out_ev_r;
  logic [clta_pkg::PM_W-1:0]          out_pm_r;
  logic signed [clta_pkg::RUN_W-1:0]  out_run_r;

  // handshakes
  logic in_fire, fin_load, sample_en, bad_limits;

  // delta path
  logic [clta_pkg::DELTA_W-1:0] dt_raw, di_raw;

  // subtract/compare unit
  logic [clta_pkg::DELTA_W:0]   rem_sh;
  logic                         rem_ge;
  logic [clta_pkg::DELTA_W:0]   rem_sub;

  // decision
  logic [clta_pkg::PM_W-1:0]          pm_q;
  logic [clta_pkg::LIM_W-1:0]         lo_lim, hi_lim, pm_ext;
  logic signed [clta_pkg::RUN_W-1:0]  run_new;
  logic                               raise, clear;
  logic [clta_pkg::EV_W-1:0]          ev_q;
  logic [clta_pkg::PM_W-1:0]          res_pm;
  logic signed [clta_pkg::RUN_W-1:0]  res_run, store_run;

  assign sample_en  = (lower_r != '0) && !bad_limits;
  assign bad_limits = (lower_r > clta_pkg::PCT_FULL) || (upper_r < lower_r);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clta_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = sample_en ? clta_pkg::ST_MUL : clta_pkg::ST_FIN;
        end
      end
      clta_pkg::ST_MUL: state_nxt = clta_pkg::ST_DIV;
      clta_pkg::ST_DIV: begin
        if (cnt_r == clta_pkg::DIV_LAST) state_nxt = clta_pkg::ST_FIN;
      end
      clta_pkg::ST_FIN: begin
        if (fin_load) state_nxt = clta_pkg::ST_IDLE;
      end
      default: state_nxt = clta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_r == clta_pkg::ST_IDLE);
    fin_load    = (state_r == clta_pkg::ST_FIN) && (!out_valid_r || out_if.ready);
  end

  assign in_fire = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clta_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r  <= clta_pkg::LOWER_RESET;
      upper_r  <= clta_pkg::UPPER_RESET;
      report_r <= clta_pkg::REPORT_RESET;
      alarm_r  <= clta_pkg::ALARM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        clta_pkg::CFG_LOWER:  lower_r  <= cfg_data;
        clta_pkg::CFG_UPPER:  upper_r  <= cfg_data;
        clta_pkg::CFG_REPORT: report_r <= cfg_data[clta_pkg::LVL_W-1:0];
        clta_pkg::CFG_ALARM:  alarm_r  <= cfg_data[clta_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  assign dt_raw = in_if.total_ticks[clta_pkg::DELTA_W-1:0] - prev_total_r;
  assign di_raw = in_if.idle_ticks[clta_pkg::DELTA_W-1:0] - prev_idle_r;

  assign rem_sh  = {rem_r, dq_r[clta_pkg::PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dt_r};
  assign rem_sub = rem_sh - {1'b0, dt_r};

  always_ff @(posedge clk) begin
    case (state_r)
      clta_pkg::ST_IDLE: begin
        if (in_fire) begin
          snap_total_r <= in_if.total_ticks[clta_pkg::DELTA_W-1:0];
          snap_idle_r  <= in_if.idle_ticks[clta_pkg::DELTA_W-1:0];
          busy_r       <= dt_raw - di_raw;
          // an empty interval counts as one tick
          dt_r         <= (dt_raw == '0) ? clta_pkg::DELTA_W'(1) : dt_raw;
        end
      end
      clta_pkg::ST_MUL: begin
        dq_r  <= clta_pkg::PROD_W'(busy_r) * clta_pkg::PROD_W'(clta_pkg::PM_SCALE);
        rem_r <= '0;
        cnt_r <= '0;
      end
      clta_pkg::ST_DIV: begin
        // remainder stays below dt, so the low 32 bits hold it
        rem_r <= rem_ge ? rem_sub[clta_pkg::DELTA_W-1:0] : rem_sh[clta_pkg::DELTA_W-1:0];
        dq_r  <= {dq_r[clta_pkg::PROD_W-2:0], rem_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------- limit compare and run counter ----------------
  always_comb begin
    pm_q   = (dq_r > clta_pkg::PROD_MAX) ? clta_pkg::PERMILLE_MAX
                                         : dq_r[clta_pkg::PM_W-1:0];
    pm_ext = clta_pkg::LIM_W'(pm_q);
    lo_lim = clta_pkg::LIM_W'(lower_r) * clta_pkg::PCT_SCALE;
    hi_lim = clta_pkg::LIM_W'(upper_r) * clta_pkg::PCT_SCALE;

    run_new = over_run_r;
    if (pm_ext < hi_lim) begin
      if (pm_ext < lo_lim) begin
        run_new = clta_pkg::RUN_IDLE;
      end else if (over_run_r < clta_pkg::SAMPLES_TO_ALARM) begin
        run_new = clta_pkg::RUN_ZERO;
      end
    end else begin
      if (over_run_r < clta_pkg::RUN_ZERO) begin
        run_new = clta_pkg::RUN_ONE;
      end else if (over_run_r < clta_pkg::SAMPLES_TO_ALARM) begin
        run_new = over_run_r + clta_pkg::RUN_ONE;
      end
    end

    raise = (run_new >= clta_pkg::SAMPLES_TO_ALARM) &&
            (over_run_r < clta_pkg::SAMPLES_TO_ALARM);
    clear = (run_new < clta_pkg::RUN_ZERO) &&
            (over_run_r >= clta_pkg::SAMPLES_TO_ALARM);

    if (lower_r == '0) begin
      ev_q      = clta_pkg::EV_NONE;
      res_pm    = '0;
      store_run = clta_pkg::RUN_IDLE;
    end else if (bad_limits) begin
      ev_q      = clta_pkg::EV_IGNORED;
      res_pm    = '0;
      store_run = over_run_r;
    end else if (raise) begin
      ev_q      = (alarm_r > report_r) ? clta_pkg::EV_BLOCKED : clta_pkg::EV_RAISE;
      res_pm    = pm_q;
      // a blocked raise leaves the counter where it was
      store_run = (alarm_r > report_r) ? over_run_r : run_new;
    end else begin
      ev_q      = clear ? clta_pkg::EV_CLEAR : clta_pkg::EV_NONE;
      res_pm    = pm_q;
      store_run = run_new;
    end
    res_run = store_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_run_r   <= clta_pkg::RUN_IDLE;
      prev_total_r <= '0;
      prev_idle_r  <= '0;
    end else if (fin_load) begin
      over_run_r <= store_run;
      if (sample_en) begin
        prev_total_r <= snap_total_r;
        prev_idle_r  <= snap_idle_r;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_ev_r  <= ev_q;
      out_pm_r  <= res_pm;
      out_run_r <= res_run;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.event_res     = out_ev_r;
  assign out_if.busy_permille = out_pm_r;
  assign out_if.run_count     = out_run_r;

endmodule

`default_nettype wire
